FILE: rtl/pdiv_pkg.sv
// shared types and constants for the (1-t) polynomial divider
package pdiv_pkg;

    localparam int MAX_LEN_DEF    = 64;
    localparam int COEF_WIDTH_DEF = 32;
    localparam int IN_W           = 32;
    localparam int OUT_W          = 32;
    localparam int IDX_OUT_W      = 6;

    // input beat: one coefficient, ascending degree
    typedef struct packed {
        logic signed [IN_W-1:0] coeff_in;
        logic                   last_in;
    } in_beat_t;

    // output beat: one reduced coefficient
    typedef struct packed {
        logic signed [OUT_W-1:0]   coeff_out;
        logic [IDX_OUT_W-1:0]      degree_index;
        logic [IDX_OUT_W-1:0]      divisions;
        logic                      last_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ALIGN,
        ST_CHECK,
        ST_PASS,
        ST_EMIT
    } state_t;

    // commands from the sequencer to the accumulator head
    typedef struct packed {
        logic clear;
        logic add_in;
        logic add_acc;
        logic upd_acc;
    } head_ctrl_t;

endpackage

FILE: rtl/pdiv_cell.sv
// one storage cell of the coefficient ring
module pdiv_cell #(
    parameter int COEF_WIDTH = pdiv_pkg::COEF_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  shift,
    input  logic [COEF_WIDTH-1:0] d,
    output logic [COEF_WIDTH-1:0] q
);
    import pdiv_pkg::*;

    logic [COEF_WIDTH-1:0] q_reg;
    logic [COEF_WIDTH-1:0] q_next;

    // takes the neighbour's value on a shift, holds otherwise
    assign q_next = shift ? d : q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: rtl/pdiv_head.sv
// prefix accumulator and coefficient sum at the head of the ring
module pdiv_head #(
    parameter int COEF_WIDTH = pdiv_pkg::COEF_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdiv_pkg::head_ctrl_t  ctrl,
    input  logic [COEF_WIDTH-1:0] coeff,
    input  logic [COEF_WIDTH-1:0] cell_q,
    output logic [COEF_WIDTH-1:0] feed,
    output logic                  sum_zero
);
    import pdiv_pkg::*;

    logic [COEF_WIDTH-1:0] acc_reg;
    logic [COEF_WIDTH-1:0] acc_next;
    logic [COEF_WIDTH-1:0] sum_reg;
    logic [COEF_WIDTH-1:0] sum_next;
    logic [COEF_WIDTH-1:0] addend;

    // running prefix sum, which is the new coefficient
    assign feed   = acc_reg + cell_q;
    assign addend = ctrl.add_in ? coeff : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
            sum_next = '0;
        end
        else
        begin
            if (ctrl.upd_acc)
                acc_next = feed;
            if (ctrl.add_in || ctrl.add_acc)
                sum_next = sum_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            sum_reg <= sum_next;
        end
    end

    assign sum_zero = (sum_reg == '0);

endmodule

FILE: rtl/poly_divide_one_minus_t_core.sv
// top level of the repeated (1-t) polynomial divider
// A polynomial arrives one coefficient per input beat, lowest degree first, the
// beat with last_in set closing it; up to MAX_LEN coefficients are kept and any
// beyond that are dropped, though their last_in still closes the polynomial.
// While the coefficient sum is zero and more than one coefficient remains, the
// block divides by (1-t), then sends the reduced coefficients in ascending
// degree, one output beat each, carrying the degree, the division count and a
// last flag. Coefficients live in a ring of MAX_LEN cells that rotates one place
// per cycle past an accumulator head while aligning or dividing; because the sum
// is zero whenever a division happens, each new coefficient is simply the
// running prefix sum of the old ones, which the head builds as the ring turns.
// A polynomial of n stored coefficients with d divisions is loaded, then the
// ring is aligned (skipped when n equals MAX_LEN), then checked, then divided d
// times, each division a full ring turn followed by a check, then sent as n - d
// output beats at one per cycle when the sink is ready. The ring turn dominates,
// so the cost follows MAX_LEN rather than n. Input is taken only while loading;
// the output beat comes straight from the head cell, which holds still while a
// beat is stalled. Coefficient arithmetic wraps modulo 2^COEF_WIDTH; input is
// sign extended to COEF_WIDTH and the output gives its low 32 bits.
module poly_divide_one_minus_t_core #(
    parameter int MAX_LEN    = pdiv_pkg::MAX_LEN_DEF,
    parameter int COEF_WIDTH = pdiv_pkg::COEF_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pdiv_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pdiv_pkg::out_beat_t out_data
);
    import pdiv_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    // sequencer state
    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [IDX_W-1:0] t_reg;
    logic [IDX_W-1:0] t_next;
    logic [IDX_W-1:0] divs_reg;
    logic [IDX_W-1:0] divs_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // ring datapath
    logic [COEF_WIDTH-1:0] cell_q [MAX_LEN];
    logic [COEF_WIDTH-1:0] ring_in;
    logic [COEF_WIDTH-1:0] coeff_ext;
    logic [COEF_WIDTH-1:0] head_feed;
    logic                  shift;
    logic                  sum_zero;
    head_ctrl_t            head_ctrl;

    // handshake and decode
    logic in_fire;
    logic out_fire;
    logic store_ok;
    logic align_done;
    logic pass_done;
    logic emit_last;
    logic can_divide;

    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid && out_ready;
    assign store_ok   = (len_reg < LEN_W'(MAX_LEN));
    assign align_done = ((LEN_W'(t_reg) + len_reg) == LEN_W'(MAX_LEN - 1));
    assign pass_done  = (t_reg == IDX_W'(MAX_LEN - 1));
    assign emit_last  = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign can_divide = sum_zero && (len_reg > LEN_W'(1));
    assign coeff_ext  = COEF_WIDTH'(in_data.coeff_in);

    // ring: cell k takes cell k+1, the top takes cell 0, input or head feed
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_ring
        if (k == MAX_LEN - 1)
        begin : g_top
            pdiv_cell #(
                .COEF_WIDTH (COEF_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (ring_in),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_mid
            pdiv_cell #(
                .COEF_WIDTH (COEF_WIDTH)
            ) u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_q[k+1]),
                .q     (cell_q[k])
            );
        end
    end

    pdiv_head #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (head_ctrl),
        .coeff    (coeff_ext),
        .cell_q   (cell_q[0]),
        .feed     (head_feed),
        .sum_zero (sum_zero)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_data.last_in)
                begin
                    // a full ring is already aligned
                    if (store_ok && ((len_reg + LEN_W'(1)) != LEN_W'(MAX_LEN)))
                        state_next = ST_ALIGN;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_ALIGN:
            begin
                if (align_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = can_divide ? ST_PASS : ST_EMIT;
            end
            ST_PASS:
            begin
                if (pass_done)
                    state_next = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (out_fire && emit_last)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // datapath control and counters
    always_comb
    begin
        shift     = 1'b0;
        ring_in   = cell_q[0];
        head_ctrl = '0;
        len_next  = len_reg;
        t_next    = t_reg;
        divs_next = divs_reg;
        idx_next  = idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                // beyond MAX_LEN a coefficient is dropped
                if (in_fire && store_ok)
                begin
                    shift          = 1'b1;
                    ring_in        = coeff_ext;
                    head_ctrl.add_in = 1'b1;
                    len_next       = len_reg + LEN_W'(1);
                end
            end
            ST_ALIGN:
            begin
                shift  = 1'b1;
                t_next = align_done ? '0 : t_reg + IDX_W'(1);
            end
            ST_CHECK:
            begin
                if (can_divide)
                    head_ctrl.clear = 1'b1;
            end
            ST_PASS:
            begin
                // cell t holds degree t; the top degree is dropped
                shift             = 1'b1;
                head_ctrl.add_acc = (LEN_W'(t_reg) < len_reg);
                head_ctrl.upd_acc = ((LEN_W'(t_reg) + LEN_W'(1)) < len_reg);
                if (head_ctrl.upd_acc)
                    ring_in = head_feed;
                if (pass_done)
                begin
                    t_next    = '0;
                    len_next  = len_reg - LEN_W'(1);
                    divs_next = divs_reg + IDX_W'(1);
                end
                else
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    shift = 1'b1;
                    if (emit_last)
                    begin
                        idx_next        = '0;
                        len_next        = '0;
                        divs_next       = '0;
                        head_ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            len_reg   <= '0;
            t_reg     <= '0;
            divs_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            t_reg     <= t_next;
            divs_reg  <= divs_next;
            idx_reg   <= idx_next;
        end
    end

    // ports
    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        out_data.coeff_out    = OUT_W'(cell_q[0]);
        out_data.degree_index = IDX_OUT_W'(idx_reg);
        out_data.divisions    = IDX_OUT_W'(divs_reg);
        out_data.last_out     = emit_last;
    end

endmodule

FILE: rtl/pdiv_checker.sv
// port-level checks for the (1-t) polynomial divider, bound to the top level
module pdiv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input pdiv_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input pdiv_pkg::out_beat_t out_data
);
    import pdiv_pkg::*;

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed while stalled");

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat dropped or changed while waiting");

    // loading and sending never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while results pending");

    // a result starts at degree zero
    a_first_degree: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_data.degree_index == '0)
        else $error("result does not start at degree zero");

    // within a result degrees step by one and the division count holds
    a_degree_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_data.last_out |=> out_valid
            && out_data.degree_index == $past(out_data.degree_index) + IDX_OUT_W'(1)
            && out_data.divisions == $past(out_data.divisions))
        else $error("degree sequence or division count broken");

endmodule

bind poly_divide_one_minus_t_core pdiv_checker u_pdiv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: sim/pdiv_divide_check.sv
// watcher for the (1-t) divider: predicts reduced coefficients and compares output beats
module pdiv_divide_check #(
    parameter int MAX_LEN = pdiv_pkg::MAX_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  pdiv_pkg::in_beat_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  pdiv_pkg::out_beat_t out_data,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the coefficient store, count and running sum
    logic [31:0]         held [MAX_LEN];
    logic [6:0]          held_n;
    logic [31:0]         held_sum;
    pdiv_pkg::out_beat_t reduced_q[$];

    // strip (1-t) factors while the sum is zero, then queue the survivors
    function automatic void divide_out_factor();
        int                  len;
        int                  divs;
        int                  i;
        logic [31:0]         carry;
        logic [31:0]         running;
        logic [31:0]         prev;
        pdiv_pkg::out_beat_t beat;
        len     = held_n;
        running = held_sum;
        divs    = 0;
        while (running == 32'h0 && len > 1)
        begin
            carry   = held[len-1];
            len     = len - 1;
            running = 32'h0;
            for (i = len; i > 0; i--)
            begin
                prev      = held[i-1];
                held[i-1] = -carry;
                running   = running + carry;
                carry     = carry + prev;
            end
            divs++;
        end
        for (i = 0; i < len; i++)
        begin
            beat.coeff_out    = held[i];
            beat.degree_index = i[5:0];
            beat.divisions    = divs[5:0];
            beat.last_out     = (i == len - 1);
            reduced_q.push_back(beat);
        end
        held_n   = '0;
        held_sum = '0;
    endfunction

    always @(posedge clk)
    begin
        pdiv_pkg::out_beat_t want;
        if (!rst_n)
        begin
            held_n      = '0;
            held_sum    = '0;
            reduced_q.delete();
            mismatches  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reduced_q.size() == 0)
                begin
                    $display("%0t: unexpected output beat %p", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = reduced_q.pop_front();
                    if (out_data.coeff_out !== want.coeff_out)
                    begin
                        $display("%0t: coeff_out expected %h got %h",
                                 $time, want.coeff_out, out_data.coeff_out);
                        mismatches++;
                    end
                    if (out_data.degree_index !== want.degree_index)
                    begin
                        $display("%0t: degree_index expected %0d got %0d",
                                 $time, want.degree_index, out_data.degree_index);
                        mismatches++;
                    end
                    if (out_data.divisions !== want.divisions)
                    begin
                        $display("%0t: divisions expected %0d got %0d",
                                 $time, want.divisions, out_data.divisions);
                        mismatches++;
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        $display("%0t: last_out expected %b got %b",
                                 $time, want.last_out, out_data.last_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                // beyond MAX_LEN the coefficient is dropped, last still closes
                if (held_n < MAX_LEN)
                begin
                    held[held_n] = in_data.coeff_in;
                    held_n       = held_n + 1'b1;
                    held_sum     = held_sum + in_data.coeff_in;
                end
                if (in_data.last_in)
                    divide_out_factor();
            end
        end
        outstanding = reduced_q.size();
    end

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

endmodule

FILE: sim/tb_top.sv
// top of the (1-t) divider testbench: clock, reset, polynomial stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN     = pdiv_pkg::MAX_LEN_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 420;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    pdiv_pkg::in_beat_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    pdiv_pkg::out_beat_t out_data;

    int          mismatches;
    int          outstanding;
    int          beats_sent  = 0;
    int          cycle_count = 0;
    logic        calm;
    logic [31:0] poly_q[$];

    // a stretch of the run in which neither side idles
    assign calm = (beats_sent >= 200 && beats_sent < 300);

    always #4 clk = ~clk;

    poly_divide_one_minus_t_core #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    pdiv_divide_check #(
        .MAX_LEN(MAX_LEN)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // sink side: ready drops about 6 percent of the time, never while calm
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 6);
    end

    // coefficient source biased towards the edges of the signed range
    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            4:       return 32'h0000_0001;
            5, 6:    return $urandom_range(15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // multiply the polynomial in poly_q by (1-t): new[i] = old[i] - old[i-1]
    function automatic void times_one_minus_t();
        int i;
        poly_q.push_back(32'h0);
        for (i = poly_q.size() - 1; i > 0; i--)
            poly_q[i] = poly_q[i] - poly_q[i-1];
    endfunction

    // one beat: optional idle cycles first, then hold valid until taken
    task automatic send_beat(input logic [31:0] coeff, input logic last);
        pdiv_pkg::in_beat_t beat;
        beat.coeff_in = coeff;
        beat.last_in  = last;
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // whole polynomial from poly_q, last flag on the top coefficient
    task automatic send_poly();
        int i;
        for (i = 0; i < poly_q.size(); i++)
            send_beat(poly_q[i], i == poly_q.size() - 1);
    endtask

    // hold the source back until every predicted beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // mostly well-formed multiples of (1-t)^k with random content, some noise
    task automatic build_random_poly(input int poly_no);
        int kind;
        int m;
        int k;
        int i;
        logic [31:0] total;
        poly_q.delete();
        kind = $urandom_range(99);
        if (poly_no == 5)
        begin
            // overflow: 64 kept with a zero sum, the extras dropped
            for (i = 0; i < MAX_LEN - 1; i++)
                poly_q.push_back(pick_coeff());
            times_one_minus_t();
            repeat ($urandom_range(8, 2))
                poly_q.push_back($urandom | 32'h1);
        end
        else if (poly_no == 12)
        begin
            // full-length all-zero polynomial, the deepest case
            repeat (MAX_LEN)
                poly_q.push_back(32'h0);
        end
        else if (kind < 60)
        begin
            m = $urandom_range(6, 1);
            k = ($urandom_range(7) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1);
            repeat (m)
                poly_q.push_back(pick_coeff());
            repeat (k)
                times_one_minus_t();
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(8, 1))
                poly_q.push_back(pick_coeff());
        end
        else if (kind < 92)
        begin
            repeat ($urandom_range(10, 1))
                poly_q.push_back(32'h0);
        end
        else if (kind < 99)
        begin
            // arbitrary content closed so that the sum wraps to zero
            total = '0;
            repeat ($urandom_range(12, 1))
            begin
                poly_q.push_back(pick_coeff());
                total = total + poly_q[$];
            end
            poly_q.push_back(-total);
        end
        else
        begin
            repeat (MAX_LEN - 2)
                poly_q.push_back(pick_coeff());
            times_one_minus_t();
            times_one_minus_t();
        end
    endtask

    // watchdog: a run that overstays the limit fails
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int poly_no;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single coefficients pass through untouched
        poly_q = '{32'h7fff_ffff};
        send_poly();
        poly_q = '{32'h8000_0000};
        send_poly();
        poly_q = '{32'h0000_0000};
        send_poly();
        // one division down to a constant
        poly_q = '{32'h0000_0001, 32'hffff_ffff};
        send_poly();
        // all zero keeps dividing until one coefficient is left
        poly_q = '{32'h0, 32'h0, 32'h0, 32'h0};
        send_poly();
        // sums that only reach zero through wrap-around
        poly_q = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001};
        send_poly();
        poly_q = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0002};
        send_poly();
        // nonzero sum, nothing to divide
        poly_q = '{32'h0000_0003, 32'h0000_0005, 32'hffff_fffe};
        send_poly();
        // (1-t)^2 exactly
        poly_q = '{32'h0000_0001, 32'hffff_fffe, 32'h0000_0001};
        send_poly();

        // let the directed beats clear before the random part
        drain();

        poly_no = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            build_random_poly(poly_no);
            send_poly();
            poly_no++;
            if (poly_no % 25 == 0)
                drain();
        end

        drain();
        // settle time in case anything stray follows the last beat
        repeat (2 * MAX_LEN)
            @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pdiv_pkg.sv
rtl/pdiv_cell.sv
rtl/pdiv_head.sv
rtl/poly_divide_one_minus_t_core.sv
rtl/pdiv_checker.sv
sim/pdiv_divide_check.sv
sim/tb_top.sv
